/* rtl/mpcs_pkg.sv */
// Shared types and command codes for the planar chord subset block.
package mpcs_pkg;

  // Point capacity of the tables; the field widths below are sized for it.
  localparam int MAX_POINTS = 64;

  typedef struct packed {
    logic [5:0] endpoint_a;
    logic [5:0] endpoint_b;
    logic       last_chord;
  } in_item_t;

  typedef struct packed {
    logic       is_count;
    logic [5:0] subset_size;
    logic [5:0] chord_low;
    logic [5:0] chord_high;
    logic       last_result;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_LOAD2,
    DP_FILL_START,
    DP_RD_PART,
    DP_RD_A,
    DP_RD_B,
    DP_RD_C,
    DP_FILL_EVAL,
    DP_RD_SIZE,
    DP_EMIT_SIZE,
    DP_WALK_START,
    DP_WALK_EVAL,
    DP_POP_RD,
    DP_POP_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic n_small;
    logic fill_last;
    logic i_lt_j;
    logic stack_empty;
    logic size_zero;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/mpcs_dp.sv */
// Datapath: partner table, interval table, interval stack and output register.
module mpcs_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  mpcs_pkg::in_item_t in_data,
  input  mpcs_pkg::dp_cmd_t  cmd,
  output mpcs_pkg::dp_status_t status,
  input  logic               out_stall,
  output logic               out_valid,
  output mpcs_pkg::out_item_t out_data
);
  import mpcs_pkg::*;

  localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int IW = ((PW > 6) ? PW : 6) + 2;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int BW = $clog2(MAX_POINTS / 2 + 1);
  localparam int BDEPTH = 1 << (2 * PW);

  logic [6:0]          nv_r;
  logic [NW-1:0]       n;
  logic signed [IW-1:0] n_s;

  logic [5:0]          pt_mem [MAX_POINTS];
  logic [5:0]          part_q_r;
  logic [BW-1:0]       best_mem [BDEPTH];
  logic [BW-1:0]       best_q_r;
  logic                rd_valid_r;
  logic [2*PW-1:0]     stk_mem [MAX_POINTS];
  logic [2*PW-1:0]     stk_q_r;
  logic [PW:0]         sp_r;

  logic [5:0]          ea_r, eb_r;
  logic signed [IW-1:0] i_r, j_r, k_r;
  logic [BW-1:0]       a_val_r, b_val_r, size_r, emit_cnt_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic signed [IW-1:0] jm1, km1, kp1, k_in;
  logic [BW-1:0]       best_rd;
  logic                best_re, best_rd_ok;
  logic [2*PW-1:0]     best_raddr;
  logic                kin, chosen;
  logic [BW:0]         with_v;
  logic [BW-1:0]       cell_v;
  logic [PW-1:0]       stk_lo, stk_hi;
  logic [PW:0]         lo_e, hi_e;

  assign n   = (32'(nv_r) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(nv_r);
  assign n_s = IW'(n);

  assign jm1  = j_r - IW'(1);
  assign km1  = k_r - IW'(1);
  assign kp1  = k_r + IW'(1);
  assign k_in = IW'(part_q_r);

  assign best_rd = rd_valid_r ? best_q_r : '0;
  assign kin     = (i_r <= k_r) && (k_r < j_r);
  assign with_v  = (BW+1)'(b_val_r) + (BW+1)'(best_rd) + (BW+1)'(1);
  assign chosen  = kin && (with_v > (BW+1)'(a_val_r));
  assign cell_v  = chosen ? with_v[BW-1:0] : a_val_r;

  assign stk_lo = stk_q_r[2*PW-1:PW];
  assign stk_hi = stk_q_r[PW-1:0];
  assign lo_e   = {1'b0, stk_lo} - (PW+1)'(1);
  assign hi_e   = {1'b0, stk_hi} + (PW+1)'(1);

  // Read address of the interval table; an empty interval reads as zero.
  always_comb begin
    best_re    = 1'b0;
    best_rd_ok = 1'b0;
    best_raddr = '0;
    unique case (cmd)
      DP_RD_A: begin
        best_re    = 1'b1;
        best_rd_ok = i_r < jm1;
        best_raddr = {i_r[PW-1:0], jm1[PW-1:0]};
      end
      DP_RD_B: begin
        best_re    = 1'b1;
        best_rd_ok = i_r < km1;
        best_raddr = {i_r[PW-1:0], km1[PW-1:0]};
      end
      DP_RD_C: begin
        best_re    = 1'b1;
        best_rd_ok = kp1 < jm1;
        best_raddr = {kp1[PW-1:0], jm1[PW-1:0]};
      end
      DP_RD_SIZE: begin
        best_re    = 1'b1;
        best_rd_ok = n_s > IW'(1);
        best_raddr = {{PW{1'b0}}, (n_s[PW-1:0] - PW'(1))};
      end
      default: begin
        best_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (best_re) begin
      best_q_r   <= best_mem[best_raddr];
      rd_valid_r <= best_rd_ok;
    end
    if (cmd == DP_FILL_EVAL) begin
      best_mem[{i_r[PW-1:0], j_r[PW-1:0]}] <= cell_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD && 32'(in_data.endpoint_a) < MAX_POINTS) begin
      pt_mem[PW'(in_data.endpoint_a)] <= in_data.endpoint_b;
    end else if (cmd == DP_LOAD2 && 32'(eb_r) < MAX_POINTS) begin
      pt_mem[PW'(eb_r)] <= ea_r;
    end
    if (cmd == DP_RD_PART) begin
      part_q_r <= pt_mem[j_r[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_WALK_EVAL && chosen) begin
      stk_mem[sp_r[PW-1:0]] <= {kp1[PW-1:0], jm1[PW-1:0]};
    end
    if (cmd == DP_POP_RD) begin
      stk_q_r <= stk_mem[sp_r[PW-1:0] - PW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= 7'd64;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        nv_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd)
        DP_LOAD: begin
          ea_r <= in_data.endpoint_a;
          eb_r <= in_data.endpoint_b;
        end
        DP_FILL_START: begin
          i_r <= '0;
          j_r <= IW'(1);
        end
        DP_RD_A: k_r <= k_in;
        DP_RD_B: a_val_r <= best_rd;
        DP_RD_C: b_val_r <= best_rd;
        DP_FILL_EVAL: begin
          if (i_r == '0) begin
            i_r <= j_r;
            j_r <= j_r + IW'(1);
          end else begin
            i_r <= i_r - IW'(1);
          end
        end
        DP_EMIT_SIZE: begin
          size_r                 <= best_rd;
          emit_cnt_r             <= '0;
          out_valid_r            <= 1'b1;
          out_data_r.is_count    <= 1'b1;
          out_data_r.subset_size <= 6'(best_rd);
          out_data_r.chord_low   <= '0;
          out_data_r.chord_high  <= '0;
          out_data_r.last_result <= best_rd == '0;
        end
        DP_WALK_START: begin
          i_r  <= '0;
          j_r  <= n_s - IW'(1);
          sp_r <= '0;
        end
        DP_WALK_EVAL: begin
          if (chosen) begin
            sp_r <= sp_r + (PW+1)'(1);
            j_r  <= km1;
          end else begin
            j_r <= jm1;
          end
        end
        DP_POP_RD: sp_r <= sp_r - (PW+1)'(1);
        DP_POP_EMIT: begin
          i_r                    <= IW'(stk_lo);
          j_r                    <= IW'(stk_hi);
          emit_cnt_r             <= emit_cnt_r + BW'(1);
          out_valid_r            <= 1'b1;
          out_data_r.is_count    <= 1'b0;
          out_data_r.subset_size <= '0;
          out_data_r.chord_low   <= 6'(lo_e);
          out_data_r.chord_high  <= 6'(hi_e);
          out_data_r.last_result <= ((BW+1)'(emit_cnt_r) + (BW+1)'(1)) == (BW+1)'(size_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign status.n_small     = n < NW'(2);
  assign status.fill_last   = (i_r == '0) && ((j_r + IW'(1)) == n_s);
  assign status.i_lt_j      = i_r < j_r;
  assign status.stack_empty = sp_r == '0;
  assign status.size_zero   = size_r == '0;
  assign status.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/mpcs_ctrl.sv */
// Controller: sequences loading, table fill, size result and backtrack walk.
module mpcs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_stall,
  input  mpcs_pkg::dp_status_t  status,
  output mpcs_pkg::dp_cmd_t     cmd
);
  import mpcs_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD, ST_LOAD2, ST_FILL_START,
    ST_F_PART, ST_F_A, ST_F_B, ST_F_C, ST_F_EV,
    ST_SIZE_RD, ST_SIZE_EMIT, ST_W_START, ST_W_TEST,
    ST_W_PART, ST_W_A, ST_W_B, ST_W_C, ST_W_EV, ST_W_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = DP_IDLE;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd       = DP_LOAD;
          last_nxt  = in_last;
          state_nxt = ST_LOAD2;
        end
      end
      ST_LOAD2: begin
        cmd       = DP_LOAD2;
        state_nxt = last_r ? ST_FILL_START : ST_LOAD;
      end
      ST_FILL_START: begin
        cmd       = DP_FILL_START;
        state_nxt = status.n_small ? ST_SIZE_RD : ST_F_PART;
      end
      ST_F_PART: begin cmd = DP_RD_PART; state_nxt = ST_F_A; end
      ST_F_A:    begin cmd = DP_RD_A;    state_nxt = ST_F_B; end
      ST_F_B:    begin cmd = DP_RD_B;    state_nxt = ST_F_C; end
      ST_F_C:    begin cmd = DP_RD_C;    state_nxt = ST_F_EV; end
      ST_F_EV: begin
        cmd       = DP_FILL_EVAL;
        state_nxt = status.fill_last ? ST_SIZE_RD : ST_F_PART;
      end
      ST_SIZE_RD: begin cmd = DP_RD_SIZE; state_nxt = ST_SIZE_EMIT; end
      ST_SIZE_EMIT: begin
        if (status.out_free) begin
          cmd       = DP_EMIT_SIZE;
          state_nxt = ST_W_START;
        end
      end
      ST_W_START: begin
        if (status.size_zero) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd       = DP_WALK_START;
          state_nxt = ST_W_TEST;
        end
      end
      ST_W_TEST: begin
        if (status.i_lt_j) begin
          state_nxt = ST_W_PART;
        end else if (status.stack_empty) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd       = DP_POP_RD;
          state_nxt = ST_W_EMIT;
        end
      end
      ST_W_PART: begin cmd = DP_RD_PART; state_nxt = ST_W_A; end
      ST_W_A:    begin cmd = DP_RD_A;    state_nxt = ST_W_B; end
      ST_W_B:    begin cmd = DP_RD_B;    state_nxt = ST_W_C; end
      ST_W_C:    begin cmd = DP_RD_C;    state_nxt = ST_W_EV; end
      ST_W_EV:   begin cmd = DP_WALK_EVAL; state_nxt = ST_W_TEST; end
      ST_W_EMIT: begin
        if (status.out_free) begin
          cmd       = DP_POP_EMIT;
          state_nxt = ST_W_TEST;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign in_stall = state_r != ST_LOAD;

endmodule

/* rtl/max_planar_chord_subset.sv */
// Top level of the maximum planar chord subset block.
//
// Chords arrive on the in_ channel, one endpoint pair per transfer; each
// transfer records both endpoints in the partner table (LOAD, then LOAD2).
// The transfer flagged last_chord starts a run: the interval table is filled
// bottom-up, n*(n-1)/2 intervals for n points; each interval takes a partner
// read, three reads on the single read port of the interval table and a write.
// The run then emits the subset size, followed by each chosen chord on the
// out_ channel; each backtrack step reads the tables, each stack pop the stack.
// No new chord is taken while a run is in progress; the next transfer is
// accepted once the walk is over, even if the final result still waits.
// The out_ channel has one output register: while the receiver holds
// out_stall the result stays put and the walk waits before its next result.
// cfg_we writes num_vertices (reset 64); values above MAX_POINTS saturate.
// Reset clears the controller, the stack pointer and the output valid; the
// tables are not cleared and need no clearing pass.
module max_planar_chord_subset (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpcs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mpcs_pkg::out_item_t out_data
);
  import mpcs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mpcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_chord),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  mpcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .status    (dp_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result is only loaded when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd == DP_EMIT_SIZE || dp_cmd == DP_POP_EMIT) |-> dp_status.out_free)
    else $error("result loaded over a pending output");

  // A chord transfer always lands in the partner table.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> dp_cmd == DP_LOAD)
    else $error("input transfer outside the load phase");

  // The walk never pops an empty stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd == DP_POP_RD |-> !dp_status.stack_empty)
    else $error("interval stack underflow");

  // Every load is followed by the second endpoint write.
  a_load_pair: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd == DP_LOAD |=> dp_cmd == DP_LOAD2)
    else $error("partner write not completed");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the maximum planar chord subset block.
`timescale 1ns / 100ps

module testbench;
  import mpcs_pkg::*;

  localparam int POINTS    = 64;
  localparam int WD_LIMIT  = 100000;
  localparam int IDLE_WAIT = 12;

  typedef struct {
    bit       cfg_en;
    bit [6:0] cfg_val;
    bit [5:0] a;
    bit [5:0] b;
    bit       last;
    bit       typed;    // expected result typed in: a lone size of zero
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int        num_pts;
  int        partner_of [POINTS];
  int        best_tab [POINTS*POINTS];
  out_item_t chord_results_q[$];
  int        errors = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;
  int        sent = 0;

  stim_row_t dir_rows[$];

  max_planar_chord_subset i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic int best(int i, int j);
    if (i < 0 || j < 0 || i >= j || j >= POINTS) return 0;
    return best_tab[i*POINTS + j];
  endfunction

  function automatic int pick_partner(int i, int j);
    int k;
    int w;
    k = partner_of[j];
    if (i <= k && k < j) begin
      w = best(i, k - 1) + best(k + 1, j - 1) + 1;
      if (w > best(i, j - 1)) return k;
    end
    return -1;
  endfunction

  // Records a chord and, on the last one, computes the subset and its walk.
  task automatic predict_chords(in_item_t it, bit typed);
    int n, i, j, k, sp, cnt;
    int stk_lo [POINTS];
    int stk_hi [POINTS];
    out_item_t r;
    partner_of[it.endpoint_a] = it.endpoint_b;
    partner_of[it.endpoint_b] = it.endpoint_a;
    if (!it.last_chord) return;
    n = (num_pts > POINTS) ? POINTS : num_pts;
    for (j = 1; j < n; j++) begin
      for (i = j - 1; i >= 0; i--) begin
        k = pick_partner(i, j);
        if (k >= 0) best_tab[i*POINTS + j] = best(i, k - 1) + best(k + 1, j - 1) + 1;
        else best_tab[i*POINTS + j] = best(i, j - 1);
      end
    end
    r = '0;
    r.is_count = 1'b1;
    r.subset_size = 6'(best(0, n - 1));
    if (typed) begin
      // Fewer than two points: only a size of zero comes out.
      r = '0;
      r.is_count = 1'b1;
      r.last_result = 1'b1;
      chord_results_q.push_back(r);
      return;
    end
    chord_results_q.push_back(r);
    cnt = 1;
    sp = 0;
    i = 0;
    j = n - 1;
    forever begin
      if (i < j) begin
        k = pick_partner(i, j);
        if (k >= 0) begin
          if (sp < POINTS) begin
            stk_lo[sp] = k + 1;
            stk_hi[sp] = j - 1;
            sp++;
          end
          j = k - 1;
        end else begin
          j = j - 1;
        end
      end else begin
        if (sp == 0) break;
        sp--;
        i = stk_lo[sp];
        j = stk_hi[sp];
        if (cnt < POINTS/2 + 1) begin
          r = '0;
          r.chord_low = 6'(i - 1);
          r.chord_high = 6'(j + 1);
          chord_results_q.push_back(r);
          cnt++;
        end
      end
    end
    chord_results_q[$].last_result = 1'b1;
  endtask

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_chord(bit [5:0] a, bit [5:0] b, bit last, bit typed);
    in_item_t it;
    it.endpoint_a = a;
    it.endpoint_b = b;
    it.last_chord = last;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    burst_left--;
    sent++;
    predict_chords(it, typed);
  endtask

  // The sender holds off until every result is in and the walk is over,
  // then the register is written.
  task automatic write_num_pts(bit [6:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (chord_results_q.size() != 0 || in_stall) @(negedge clk);
    @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    num_pts = v;
  endtask

  function automatic stim_row_t row(bit c, bit [6:0] v, bit [5:0] a, bit [5:0] b, bit l,
                                    bit t);
    stim_row_t s;
    s.cfg_en = c;
    s.cfg_val = v;
    s.a = a;
    s.b = b;
    s.last = l;
    s.typed = t;
    return s;
  endfunction

  // Receiver stall pattern: phases of no stall, random stall, and long holds.
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 200);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Values are stable from the falling edge up to the next rising edge.
  always @(negedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, WD_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (chord_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors++;
        end else begin
          e = chord_results_q.pop_front();
          if (out_data.is_count !== e.is_count) begin
            $display("%0t: is_count expected %0d actual %0d", $time, e.is_count,
                     out_data.is_count);
            errors++;
          end
          if (out_data.subset_size !== e.subset_size) begin
            $display("%0t: subset_size expected %0d actual %0d", $time, e.subset_size,
                     out_data.subset_size);
            errors++;
          end
          if (out_data.chord_low !== e.chord_low) begin
            $display("%0t: chord_low expected %0d actual %0d", $time, e.chord_low,
                     out_data.chord_low);
            errors++;
          end
          if (out_data.chord_high !== e.chord_high) begin
            $display("%0t: chord_high expected %0d actual %0d", $time, e.chord_high,
                     out_data.chord_high);
            errors++;
          end
          if (out_data.last_result !== e.last_result) begin
            $display("%0t: last_result expected %0d actual %0d", $time, e.last_result,
                     out_data.last_result);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int n, m, nitems, t, x;
    int pts[$];
    for (int p = 0; p < POINTS; p++) partner_of[p] = 0;
    for (int p = 0; p < POINTS*POINTS; p++) best_tab[p] = 0;
    num_pts = 64;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every partner entry is written first: nested chords over all 64 points.
    for (int c = 0; c < POINTS/2; c++)
      send_chord(6'(c), 6'(63 - c), c == POINTS/2 - 1, 1'b0);

    dir_rows.push_back(row(1, 7'd0,   6'd0,  6'd63, 1, 1));
    dir_rows.push_back(row(1, 7'd1,   6'd5,  6'd6,  1, 1));
    dir_rows.push_back(row(1, 7'd2,   6'd0,  6'd1,  1, 0));
    dir_rows.push_back(row(1, 7'd127, 6'd63, 6'd0,  1, 0));
    dir_rows.push_back(row(1, 7'd4,   6'd0,  6'd2,  0, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd1,  6'd3,  1, 0));
    dir_rows.push_back(row(1, 7'd8,   6'd0,  6'd7,  0, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd1,  6'd6,  0, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd2,  6'd5,  0, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd3,  6'd4,  1, 0));
    dir_rows.push_back(row(1, 7'd8,   6'd4,  6'd4,  1, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd2,  6'd60, 1, 0));
    dir_rows.push_back(row(1, 7'd7,   6'd6,  6'd0,  1, 0));
    dir_rows.push_back(row(1, 7'd64,  6'd62, 6'd63, 0, 0));
    dir_rows.push_back(row(0, 7'd0,   6'd42, 6'd21, 1, 0));
    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg_en) write_num_pts(dir_rows[r].cfg_val);
      send_chord(dir_rows[r].a, dir_rows[r].b, dir_rows[r].last, dir_rows[r].typed);
    end

    while (sent < 90) begin
      t = $urandom_range(0, 9);
      if (t == 0) n = 64;
      else if (t == 1) n = $urandom_range(0, 127);
      else n = 2 * $urandom_range(1, 8);
      write_num_pts(7'(n));
      if ($urandom_range(0, 3) != 0) begin
        // A random perfect matching over the points in use, made even and at least two.
        m = (n > POINTS) ? POINTS : n;
        m = m & ~1;
        if (m < 2) m = 2;
        pts.delete();
        for (int p = 0; p < m; p++) pts.push_back(p);
        for (int p = m - 1; p > 0; p--) begin
          t = $urandom_range(0, p);
          x = pts[p];
          pts[p] = pts[t];
          pts[t] = x;
        end
        for (int p = 0; p < m; p += 2)
          send_chord(6'(pts[p]), 6'(pts[p+1]), p == m - 2, 1'b0);
      end else begin
        nitems = $urandom_range(1, 6);
        for (int p = 0; p < nitems; p++)
          send_chord(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                     p == nitems - 1, n < 2);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (chord_results_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
